// ----- hdl/qs_pkg.sv -----
`default_nettype none
package qs_pkg;

  // Fixed point formats
  localparam int FRAC_BITS = 14;
  localparam int TRIG_Q    = 28;

  localparam logic [29:0] PI_Q28      = 30'd843314857;
  localparam logic [28:0] HALF_PI_Q28 = 29'd421657428;

  // Configuration register indexes
  localparam logic REG_MODE = 1'b0;
  localparam logic REG_THR  = 1'b1;

  // Taylor series for sine: eight terms after x, divisors n(n+1) for n = 2, 4 .. 16.
  // Each divide by n(n+1) is a multiply by ceil(2^s / d) and a right shift by s,
  // exact for dividends below 2^30.
  localparam int TERMS = 8;
  localparam logic [31:0] TAYLOR_MUL [TERMS] = '{
    32'd1431655766,  // 6
    32'd1717986919,  // 20
    32'd1636178018,  // 42
    32'd1908874354,  // 72
    32'd1249445032,  // 110
    32'd1762037866,  // 156
    32'd1308942415,  // 210
    32'd2021161081   // 272
  };
  localparam int TAYLOR_SHIFT [TERMS] = '{33, 35, 36, 37, 37, 38, 38, 39};

  // Pipeline depths
  localparam int SIN_LAT    = 2 * TERMS + 1;
  localparam int STEP_LAT   = SIN_LAT + 2;
  localparam int ACOS_STEPS = 29;
  localparam int ACOS_LAT   = ACOS_STEPS * STEP_LAT;

  // Weight divider
  localparam int DIV_W   = 44;
  localparam int DEN_W   = 30;
  localparam int DIV_LAT = DIV_W;

  // Weight clamp and widths
  localparam int WGT_W = 42;
  localparam logic [DIV_W-1:0] WGT_LIMIT = DIV_W'(1) << 40;

  // Arccosine search state
  typedef struct packed {
    logic [28:0] lo;
    logic [28:0] hi;
    logic [27:0] c;
  } srch_t;

endpackage
`default_nettype wire

// ----- hdl/qs_sin.sv -----
`default_nettype none
// Pipelined Q28 sine for arguments already folded into [-pi/2, pi/2].
// Stage 0 squares the argument, then each term takes a multiply stage and a
// divide-by-constant stage. Term magnitude and sign travel separately so every
// truncation goes toward zero.
module qs_sin
  import qs_pkg::*;
(
  input  wire logic               clk,
  input  wire logic signed [30:0] ang,
  output logic signed [30:0]      sin_o
);

  logic [29:0]        mag_r [0:SIN_LAT-1];
  logic [29:0]        x2_r  [0:SIN_LAT-1];
  logic               neg_r [0:SIN_LAT-1];
  logic signed [30:0] sum_r [0:SIN_LAT-1];

  logic [29:0] ang_mag;
  logic [59:0] sq;

  assign ang_mag = ang[30] ? 30'(-ang) : 30'(ang);
  assign sq      = 60'(ang_mag) * 60'(ang_mag);

  // square of the argument
  always_ff @(posedge clk) begin
    mag_r[0] <= ang_mag;
    x2_r[0]  <= 30'(sq >> TRIG_Q);
    neg_r[0] <= ang[30];
    sum_r[0] <= ang;
  end

  for (genvar j = 0; j < TERMS; j++) begin : g_term
    logic [59:0] prod;
    logic [61:0] recip;
    logic [29:0] quo;

    assign prod  = 60'(mag_r[2*j]) * 60'(x2_r[2*j]);
    assign recip = 62'(mag_r[2*j+1]) * 62'(TAYLOR_MUL[j]);
    assign quo   = 30'(recip >> TAYLOR_SHIFT[j]);

    // term * x^2, truncated
    always_ff @(posedge clk) begin
      mag_r[2*j+1] <= 30'(prod >> TRIG_Q);
      x2_r[2*j+1]  <= x2_r[2*j];
      neg_r[2*j+1] <= neg_r[2*j];
      sum_r[2*j+1] <= sum_r[2*j];
    end

    // divide by n(n+1), flip sign, accumulate
    always_ff @(posedge clk) begin
      mag_r[2*j+2] <= quo;
      x2_r[2*j+2]  <= x2_r[2*j+1];
      neg_r[2*j+2] <= ~neg_r[2*j+1];
      if (neg_r[2*j+1]) begin
        sum_r[2*j+2] <= sum_r[2*j+1] + $signed({1'b0, quo});
      end else begin
        sum_r[2*j+2] <= sum_r[2*j+1] - $signed({1'b0, quo});
      end
    end
  end

  assign sin_o = sum_r[SIN_LAT-1];

endmodule
`default_nettype wire

// ----- hdl/qs_acos_step.sv -----
`default_nettype none
// One step of the arccosine binary search: probes cos(mid) through a sine
// pipeline and narrows [lo, hi]. A finished search passes through unchanged.
module qs_acos_step
  import qs_pkg::*;
(
  input  wire logic  clk,
  input  wire srch_t s_i,
  output srch_t      s_o
);

  logic [29:0]        mid_sum;
  logic [28:0]        mid;
  logic signed [30:0] ang_r;
  logic signed [30:0] cos_w;
  srch_t              s_r   [0:SIN_LAT];
  logic [28:0]        mid_r [0:SIN_LAT];
  srch_t              s_nxt;

  assign mid_sum = 30'(s_i.lo) + 30'(s_i.hi) + 30'd1;
  assign mid     = mid_sum[29:1];

  // cos(mid) = sin(pi/2 - mid), argument already in range
  always_ff @(posedge clk) begin
    ang_r    <= $signed(31'(HALF_PI_Q28 - mid));
    s_r[0]   <= s_i;
    mid_r[0] <= mid;
    for (int i = 1; i <= SIN_LAT; i++) begin
      s_r[i]   <= s_r[i-1];
      mid_r[i] <= mid_r[i-1];
    end
  end

  qs_sin u_cos (
    .clk   (clk),
    .ang   (ang_r),
    .sin_o (cos_w)
  );

  // narrow the interval
  always_comb begin
    s_nxt = s_r[SIN_LAT];
    if (s_r[SIN_LAT].lo < s_r[SIN_LAT].hi) begin
      if (cos_w >= $signed({3'b000, s_r[SIN_LAT].c})) begin
        s_nxt.lo = mid_r[SIN_LAT];
      end else begin
        s_nxt.hi = mid_r[SIN_LAT] - 29'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    s_o <= s_nxt;
  end

endmodule
`default_nettype wire

// ----- hdl/qs_div.sv -----
`default_nettype none
// Pipelined restoring divider, one quotient bit per stage. The numerator
// shifts out at the top of nq while quotient bits shift in at the bottom.
module qs_div
  import qs_pkg::*;
(
  input  wire logic             clk,
  input  wire logic [DIV_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic [DIV_W-1:0]      quo
);

  logic [DEN_W-1:0] rem_r [0:DIV_W-1];
  logic [DIV_W-1:0] nq_r  [0:DIV_W-1];
  logic [DEN_W-1:0] den_r [0:DIV_W-1];

  for (genvar k = 0; k < DIV_W; k++) begin : g_bit
    logic [DEN_W-1:0] rem_in;
    logic [DIV_W-1:0] nq_in;
    logic [DEN_W-1:0] den_in;
    logic [DEN_W:0]   trial;
    logic             fits;

    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign nq_in  = num;
      assign den_in = den;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign nq_in  = nq_r[k-1];
      assign den_in = den_r[k-1];
    end

    assign trial = {rem_in, nq_in[DIV_W-1]};
    assign fits  = trial >= {1'b0, den_in};

    always_ff @(posedge clk) begin
      rem_r[k] <= fits ? DEN_W'(trial - {1'b0, den_in}) : trial[DEN_W-1:0];
      nq_r[k]  <= {nq_in[DIV_W-2:0], fits};
      den_r[k] <= den_in;
    end
  end

  assign quo = nq_r[DIV_W-1];

endmodule
`default_nettype wire

// ----- hdl/quaternion_slerp_top.sv -----
`default_nettype none
// Quaternion interpolation, Q1.14. One item enters per clock whenever start
// is high (busy stays low) and its result appears on out_* with out_valid,
// one result per item, in order; the output cannot be held off, so the
// receiver must take every strobe. The pipeline is dominated by the arccosine
// search: 29 binary search steps, every step a full Taylor sine pipeline,
// followed by the weight sines and a 44-stage restoring divider.
// Configuration writes are always ready and must only be made while no
// item is in flight.
module quaternion_slerp_top
  import qs_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic signed [15:0] in_a_x,
  input  wire logic signed [15:0] in_a_y,
  input  wire logic signed [15:0] in_a_z,
  input  wire logic signed [15:0] in_a_w,
  input  wire logic signed [15:0] in_b_x,
  input  wire logic signed [15:0] in_b_y,
  input  wire logic signed [15:0] in_b_z,
  input  wire logic signed [15:0] in_b_w,
  input  wire logic [14:0]        in_blend_weight,
  output logic                    out_valid,
  output logic signed [15:0]      out_x,
  output logic signed [15:0]      out_y,
  output logic signed [15:0]      out_z,
  output logic signed [15:0]      out_w,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic               cfg_index,
  input  wire logic [14:0]        cfg_data
);

  localparam int TAP_ARG  = ACOS_LAT;
  localparam int TAP_WGT  = ACOS_LAT + 2 + SIN_LAT + 1 + DIV_LAT;
  localparam int TAP_FIN  = TAP_WGT + 1;
  localparam int SIDE_LEN = TAP_FIN + 2;

  localparam logic [15:0] ONE_W = 16'(1) << FRAC_BITS;

  typedef struct packed {
    logic [3:0][15:0] a;
    logic [3:0][16:0] b;
    logic [14:0]      t;
    logic             lin;
  } side_t;

  typedef struct packed {
    logic sg0;
    logic sg1;
    logic stpos;
  } dsg_t;

  function automatic logic signed [30:0] fold_ang(input logic [29:0] m, input logic neg);
    logic [29:0] f;
    f = (m > 30'(HALF_PI_Q28)) ? PI_Q28 - m : m;
    return neg ? -$signed({1'b0, f}) : $signed({1'b0, f});
  endfunction

  function automatic logic signed [WGT_W-1:0] make_wgt(input logic [DIV_W-1:0] q,
                                                       input logic neg);
    logic [DIV_W-1:0] m;
    m = (q > WGT_LIMIT) ? WGT_LIMIT : q;
    return neg ? -$signed(WGT_W'(m)) : $signed(WGT_W'(m));
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [45:0] v);
    if (v > 46'sd32767) begin
      return 16'sh7fff;
    end else if (v < -46'sd32768) begin
      return 16'sh8000;
    end
    return 16'(v);
  endfunction

  // configuration registers
  logic        mode_r;
  logic [14:0] thr_r;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
      thr_r  <= 15'd16;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MODE: mode_r <= cfg_data[0];
        REG_THR:  thr_r  <= cfg_data;
        default:  ;
      endcase
    end
  end

  // stage 1: register item, component products
  logic signed [15:0] in_a [4];
  logic signed [15:0] in_b [4];
  logic               s1_vld_r;
  logic signed [15:0] s1_a_r [4];
  logic signed [15:0] s1_b_r [4];
  logic signed [31:0] s1_p_r [4];
  logic [14:0]        s1_t_r;

  assign in_a[0] = in_a_x;
  assign in_a[1] = in_a_y;
  assign in_a[2] = in_a_z;
  assign in_a[3] = in_a_w;
  assign in_b[0] = in_b_x;
  assign in_b[1] = in_b_y;
  assign in_b[2] = in_b_z;
  assign in_b[3] = in_b_w;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      s1_a_r[i] <= in_a[i];
      s1_b_r[i] <= in_b[i];
      s1_p_r[i] <= 32'(in_a[i]) * 32'(in_b[i]);
    end
    s1_t_r <= in_blend_weight;
  end

  // stage 2: dot product, sign fix, near test
  logic signed [33:0] raw;
  logic [32:0]        raw_mag;
  logic signed [34:0] gap;
  logic signed [34:0] thr_q;
  logic               sph;
  side_t              side_nxt;
  srch_t              srch_nxt;

  assign raw     = 34'(s1_p_r[0]) + 34'(s1_p_r[1]) + 34'(s1_p_r[2]) + 34'(s1_p_r[3]);
  assign raw_mag = raw[33] ? 33'(-raw) : 33'(raw);
  assign gap     = $signed(35'(1) << (2 * FRAC_BITS)) - $signed({2'b00, raw_mag});
  assign thr_q   = $signed(35'(thr_r) << FRAC_BITS);
  assign sph     = !mode_r && (gap > thr_q);

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      side_nxt.a[i] = s1_a_r[i];
      side_nxt.b[i] = raw[33] ? -17'(s1_b_r[i]) : 17'(s1_b_r[i]);
    end
    side_nxt.t   = s1_t_r;
    side_nxt.lin = !sph;
    srch_nxt.lo  = '0;
    srch_nxt.hi  = HALF_PI_Q28;
    // dot is already Q28 at 14 fraction bits
    srch_nxt.c   = 28'(raw_mag >> (2 * FRAC_BITS - TRIG_Q));
  end

  // side band delay line, valid bits travel with it
  side_t               side_r [0:SIDE_LEN-1];
  logic [SIDE_LEN-1:0] vld_r;
  srch_t               srch0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[SIDE_LEN-2:0], s1_vld_r};
    end
  end

  always_ff @(posedge clk) begin
    side_r[0] <= side_nxt;
    srch0_r   <= srch_nxt;
    for (int i = 1; i < SIDE_LEN; i++) begin
      side_r[i] <= side_r[i-1];
    end
  end

  // arccosine search chain
  srch_t srch_w [0:ACOS_STEPS];

  assign srch_w[0] = srch0_r;

  for (genvar g = 0; g < ACOS_STEPS; g++) begin : g_acos
    qs_acos_step u_step (
      .clk (clk),
      .s_i (srch_w[g]),
      .s_o (srch_w[g+1])
    );
  end

  // sine arguments: theta * k, truncated toward zero, then folded
  logic [28:0]        theta;
  logic [14:0]        t_arg;
  logic [15:0]        k0_lin;
  logic [14:0]        k0_mag;
  logic [43:0]        ap0_r;
  logic [43:0]        ap1_r;
  logic               an0_r;
  logic [28:0]        th1_r;
  logic signed [30:0] ang0_r;
  logic signed [30:0] ang1_r;
  logic signed [30:0] th2_r;

  assign theta  = srch_w[ACOS_STEPS].lo;
  assign t_arg  = side_r[TAP_ARG].t;
  assign k0_lin = ONE_W - 16'(t_arg);
  assign k0_mag = k0_lin[15] ? 15'(-k0_lin) : 15'(k0_lin);

  always_ff @(posedge clk) begin
    ap0_r  <= 44'(theta) * 44'(k0_mag);
    ap1_r  <= 44'(theta) * 44'(t_arg);
    an0_r  <= k0_lin[15];
    th1_r  <= theta;
    ang0_r <= fold_ang(30'(ap0_r >> FRAC_BITS), an0_r);
    ang1_r <= fold_ang(30'(ap1_r >> FRAC_BITS), 1'b0);
    th2_r  <= $signed(31'(th1_r));
  end

  // sin(theta), sin((1-t)theta), sin(t theta)
  logic signed [30:0] st_w;
  logic signed [30:0] s0_w;
  logic signed [30:0] s1_w;

  qs_sin u_sin_th (.clk(clk), .ang(th2_r),  .sin_o(st_w));
  qs_sin u_sin_k0 (.clk(clk), .ang(ang0_r), .sin_o(s0_w));
  qs_sin u_sin_k1 (.clk(clk), .ang(ang1_r), .sin_o(s1_w));

  // divider operands
  logic [DIV_W-1:0] num0_r;
  logic [DIV_W-1:0] num1_r;
  logic [DEN_W-1:0] den_r;
  dsg_t             dsg_r [0:DIV_LAT];

  always_ff @(posedge clk) begin
    num0_r       <= DIV_W'(s0_w[30] ? 30'(-s0_w) : 30'(s0_w)) << FRAC_BITS;
    num1_r       <= DIV_W'(s1_w[30] ? 30'(-s1_w) : 30'(s1_w)) << FRAC_BITS;
    den_r        <= DEN_W'(st_w);
    dsg_r[0].sg0   <= s0_w[30];
    dsg_r[0].sg1   <= s1_w[30];
    dsg_r[0].stpos <= !st_w[30] && (st_w != '0);
    for (int i = 1; i <= DIV_LAT; i++) begin
      dsg_r[i] <= dsg_r[i-1];
    end
  end

  logic [DIV_W-1:0] quo0_w;
  logic [DIV_W-1:0] quo1_w;

  qs_div u_div0 (.clk(clk), .num(num0_r), .den(den_r), .quo(quo0_w));
  qs_div u_div1 (.clk(clk), .num(num1_r), .den(den_r), .quo(quo1_w));

  // weight select: spherical or linear
  logic                    use_sph;
  logic [15:0]             k0_fin;
  logic signed [WGT_W-1:0] k0_r;
  logic signed [WGT_W-1:0] k1_r;

  assign use_sph = !side_r[TAP_WGT].lin && dsg_r[DIV_LAT].stpos;
  assign k0_fin  = ONE_W - 16'(side_r[TAP_WGT].t);

  always_ff @(posedge clk) begin
    if (use_sph) begin
      k0_r <= make_wgt(quo0_w, dsg_r[DIV_LAT].sg0);
      k1_r <= make_wgt(quo1_w, dsg_r[DIV_LAT].sg1);
    end else begin
      k0_r <= WGT_W'($signed(k0_fin));
      k1_r <= $signed(WGT_W'(side_r[TAP_WGT].t));
    end
  end

  // blend products
  logic signed [59:0] pa_r [4];
  logic signed [59:0] pb_r [4];

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      pa_r[i] <= 60'($signed(side_r[TAP_FIN].a[i])) * 60'(k0_r);
      pb_r[i] <= 60'($signed(side_r[TAP_FIN].b[i])) * 60'(k1_r);
    end
  end

  // round half up, saturate
  logic signed [59:0] sum_w [4];
  logic signed [15:0] res_r [4];
  logic               out_valid_r;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      sum_w[i] = pa_r[i] + pb_r[i] + (60'sd1 <<< (FRAC_BITS - 1));
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      res_r[i] <= sat16(46'(sum_w[i] >>> FRAC_BITS));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= vld_r[TAP_FIN+1];
    end
  end

  assign out_valid = out_valid_r;
  assign out_x     = res_r[0];
  assign out_y     = res_r[1];
  assign out_z     = res_r[2];
  assign out_w     = res_r[3];

endmodule
`default_nettype wire
